// ===== rtl/polyline_length_accumulator_defines.svh =====
// ----------------------------------------------------------------------------
// polyline_length_accumulator_defines.svh
// Assertion macros used by the polyline length accumulator back end (pla_back).
// ----------------------------------------------------------------------------
`ifndef POLYLINE_LENGTH_ACCUMULATOR_DEFINES_SVH
`define POLYLINE_LENGTH_ACCUMULATOR_DEFINES_SVH

// Check that expr holds at every clock edge outside reset.
`define PLA_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that cons holds in the same cycle as ante.
`define PLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define PLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pla_pkg.sv =====
// ----------------------------------------------------------------------------
// pla_pkg
// Widths, queue entry and status types for the polyline length accumulator.
// ----------------------------------------------------------------------------
package pla_pkg;

    // Coordinate width; the fraction position does not change any logic.
    localparam int COORD_BITS    = 24;
    localparam int SQ_BITS       = 2 * COORD_BITS;
    localparam int ROOT_BITS     = COORD_BITS + 1;
    localparam int RAD_BITS      = 2 * ROOT_BITS;
    localparam int REM_BITS      = ROOT_BITS + 1;
    localparam int STEP_BITS     = ROOT_BITS + 3;
    localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS);

    localparam int CHAIN_BITS = 40;
    localparam int BATCH_BITS = 44;
    localparam int COUNT_BITS = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic                  chain_start;
        logic                  chain_end;
        logic                  batch_end;
    } pla_item_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } pla_qstat_t;

endpackage

// ===== rtl/pla_front.sv =====
// ----------------------------------------------------------------------------
// pla_front
// Accept points, measure |dx| and |dy| against the stored previous point.
// ----------------------------------------------------------------------------
module pla_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pla_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [pla_pkg::COORD_BITS-1:0] coord_y,
    input  logic                                  chain_start,
    input  logic                                  chain_end,
    input  logic                                  batch_end,
    input  pla_pkg::pla_qstat_t                   q_stat,
    output logic                                  push,
    output pla_pkg::pla_item_t                    push_item
);

    logic [pla_pkg::COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic [pla_pkg::COORD_BITS-1:0] prev_y_reg, prev_y_next;
    logic [pla_pkg::COORD_BITS:0]   diff_x;
    logic [pla_pkg::COORD_BITS:0]   diff_y;
    logic [pla_pkg::COORD_BITS:0]   mag_x;
    logic [pla_pkg::COORD_BITS:0]   mag_y;

    assign in_ready = q_stat.not_full;
    assign push     = in_valid && in_ready;

    // sign-extended difference, then magnitude
    always_comb
    begin
        diff_x = {coord_x[pla_pkg::COORD_BITS-1], coord_x}
               - {prev_x_reg[pla_pkg::COORD_BITS-1], prev_x_reg};
        diff_y = {coord_y[pla_pkg::COORD_BITS-1], coord_y}
               - {prev_y_reg[pla_pkg::COORD_BITS-1], prev_y_reg};
        mag_x  = diff_x[pla_pkg::COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
        mag_y  = diff_y[pla_pkg::COORD_BITS] ? (~diff_y + 1'b1) : diff_y;

        push_item.dx          = mag_x[pla_pkg::COORD_BITS-1:0];
        push_item.dy          = mag_y[pla_pkg::COORD_BITS-1:0];
        push_item.chain_start = chain_start;
        push_item.chain_end   = chain_end;
        push_item.batch_end   = batch_end;
    end

    always_comb
    begin
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        if (push)
        begin
            prev_x_next = coord_x;
            prev_y_next = coord_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end
        else
        begin
            prev_x_reg <= prev_x_next;
            prev_y_reg <= prev_y_next;
        end
    end

endmodule

// ===== rtl/pla_queue.sv =====
// ----------------------------------------------------------------------------
// pla_queue
// Short FIFO of measured points between front and back.
// ----------------------------------------------------------------------------
module pla_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pla_pkg::pla_item_t  push_item,
    input  logic                pop,
    output pla_pkg::pla_item_t  pop_item,
    output pla_pkg::pla_qstat_t q_stat
);

    pla_pkg::pla_item_t              mem_reg [pla_pkg::QUEUE_DEPTH];
    logic [pla_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pla_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pla_pkg::QCNT_BITS-1:0]   count_reg, count_next;

    function automatic logic [pla_pkg::QPTR_BITS-1:0] ptr_inc(
        input logic [pla_pkg::QPTR_BITS-1:0] ptr
    );
        if (ptr == pla_pkg::QPTR_BITS'(pla_pkg::QUEUE_DEPTH - 1))
            return '0;
        return ptr + 1'b1;
    endfunction

    assign pop_item         = mem_reg[rd_ptr_reg];
    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.not_full  = (count_reg != pla_pkg::QCNT_BITS'(pla_pkg::QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/pla_back.sv =====
// ----------------------------------------------------------------------------
// pla_back
// Square, bit-serial square root, saturating accumulation, result register.
// ----------------------------------------------------------------------------
`include "polyline_length_accumulator_defines.svh"

module pla_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pla_pkg::pla_qstat_t                  q_stat,
    input  pla_pkg::pla_item_t                   pop_item,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [pla_pkg::CHAIN_BITS-1:0]       chain_length,
    output logic [pla_pkg::BATCH_BITS-1:0]       total_length,
    output logic [pla_pkg::COUNT_BITS-1:0]       chain_points,
    output logic [pla_pkg::COUNT_BITS-1:0]       total_points,
    output logic                                 last_of_batch
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SQUARE = 5'b00010,
        S_SUM    = 5'b00100,
        S_ROOT   = 5'b01000,
        S_ACCUM  = 5'b10000
    } pla_state_t;

    pla_state_t                          state_reg, state_next;
    pla_pkg::pla_item_t                  item_reg, item_next;
    logic [pla_pkg::SQ_BITS-1:0]         sq_x_reg, sq_x_next;
    logic [pla_pkg::SQ_BITS-1:0]         sq_y_reg, sq_y_next;
    logic [pla_pkg::RAD_BITS-1:0]        rad_reg, rad_next;
    logic [pla_pkg::REM_BITS-1:0]        rem_reg, rem_next;
    logic [pla_pkg::ROOT_BITS-1:0]       res_reg, res_next;
    logic [pla_pkg::ROOT_CNT_BITS-1:0]   cnt_reg, cnt_next;

    logic [pla_pkg::CHAIN_BITS-1:0]      chain_sum_reg, chain_sum_next;
    logic [pla_pkg::BATCH_BITS-1:0]      batch_sum_reg, batch_sum_next;
    logic [pla_pkg::COUNT_BITS-1:0]      chain_count_reg, chain_count_next;
    logic [pla_pkg::COUNT_BITS-1:0]      batch_count_reg, batch_count_next;

    logic                                out_valid_reg, out_valid_next;
    logic [pla_pkg::CHAIN_BITS-1:0]      out_chain_reg, out_chain_next;
    logic [pla_pkg::BATCH_BITS-1:0]      out_batch_reg, out_batch_next;
    logic [pla_pkg::COUNT_BITS-1:0]      out_ccnt_reg, out_ccnt_next;
    logic [pla_pkg::COUNT_BITS-1:0]      out_bcnt_reg, out_bcnt_next;
    logic                                out_last_reg, out_last_next;

    logic [pla_pkg::STEP_BITS-1:0]       rem_shift;
    logic [pla_pkg::STEP_BITS-1:0]       trial;
    logic                                root_ge;
    logic [pla_pkg::CHAIN_BITS-1:0]      chain_base;
    logic [pla_pkg::COUNT_BITS-1:0]      ccnt_base;
    logic [pla_pkg::CHAIN_BITS:0]        chain_add;
    logic [pla_pkg::BATCH_BITS:0]        batch_add;
    logic [pla_pkg::COUNT_BITS:0]        ccnt_add;
    logic [pla_pkg::COUNT_BITS:0]        bcnt_add;
    logic [pla_pkg::CHAIN_BITS-1:0]      chain_new;
    logic [pla_pkg::BATCH_BITS-1:0]      batch_new;
    logic [pla_pkg::COUNT_BITS-1:0]      ccnt_new;
    logic [pla_pkg::COUNT_BITS-1:0]      bcnt_new;
    logic                                out_free;

    assign out_valid     = out_valid_reg;
    assign chain_length  = out_chain_reg;
    assign total_length  = out_batch_reg;
    assign chain_points  = out_ccnt_reg;
    assign total_points  = out_bcnt_reg;
    assign last_of_batch = out_last_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == S_IDLE) && q_stat.not_empty;

    // one root digit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[pla_pkg::RAD_BITS-1 -: 2]};
        trial     = {1'b0, res_reg, 2'b01};
        root_ge   = (rem_shift >= trial);
    end

    // saturating sums; a chain start restarts the chain terms
    always_comb
    begin
        chain_base = item_reg.chain_start ? '0 : chain_sum_reg;
        ccnt_base  = item_reg.chain_start ? '0 : chain_count_reg;
        chain_add  = {1'b0, chain_base} + (pla_pkg::CHAIN_BITS + 1)'(res_reg);
        batch_add  = {1'b0, batch_sum_reg} + (pla_pkg::BATCH_BITS + 1)'(res_reg);
        ccnt_add   = {1'b0, ccnt_base} + 1'b1;
        bcnt_add   = {1'b0, batch_count_reg} + 1'b1;
        chain_new  = chain_add[pla_pkg::CHAIN_BITS] ? '1
                                                    : chain_add[pla_pkg::CHAIN_BITS-1:0];
        batch_new  = batch_add[pla_pkg::BATCH_BITS] ? '1
                                                    : batch_add[pla_pkg::BATCH_BITS-1:0];
        ccnt_new   = ccnt_add[pla_pkg::COUNT_BITS] ? '1 : ccnt_add[pla_pkg::COUNT_BITS-1:0];
        bcnt_new   = bcnt_add[pla_pkg::COUNT_BITS] ? '1 : bcnt_add[pla_pkg::COUNT_BITS-1:0];
    end

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        sq_x_next        = sq_x_reg;
        sq_y_next        = sq_y_reg;
        rad_next         = rad_reg;
        rem_next         = rem_reg;
        res_next         = res_reg;
        cnt_next         = cnt_reg;
        chain_sum_next   = chain_sum_reg;
        batch_sum_next   = batch_sum_reg;
        chain_count_next = chain_count_reg;
        batch_count_next = batch_count_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_chain_next   = out_chain_reg;
        out_batch_next   = out_batch_reg;
        out_ccnt_next    = out_ccnt_reg;
        out_bcnt_next    = out_bcnt_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_stat.not_empty)
                begin
                    item_next  = pop_item;
                    res_next   = '0;
                    state_next = pop_item.chain_start ? S_ACCUM : S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                sq_x_next  = item_reg.dx * item_reg.dx;
                sq_y_next  = item_reg.dy * item_reg.dy;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                rad_next   = pla_pkg::RAD_BITS'({1'b0, sq_x_reg} + {1'b0, sq_y_reg});
                rem_next   = '0;
                res_next   = '0;
                cnt_next   = '0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                rem_next = root_ge ? pla_pkg::REM_BITS'(rem_shift - trial)
                                   : rem_shift[pla_pkg::REM_BITS-1:0];
                res_next = {res_reg[pla_pkg::ROOT_BITS-2:0], root_ge};
                rad_next = rad_reg << 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == pla_pkg::ROOT_CNT_BITS'(pla_pkg::ROOT_BITS - 1))
                    state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                if (!item_reg.chain_end)
                begin
                    chain_sum_next   = chain_new;
                    batch_sum_next   = batch_new;
                    chain_count_next = ccnt_new;
                    batch_count_next = bcnt_new;
                    state_next       = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_chain_next   = chain_new;
                    out_batch_next   = batch_new;
                    out_ccnt_next    = ccnt_new;
                    out_bcnt_next    = bcnt_new;
                    out_last_next    = item_reg.batch_end;
                    chain_sum_next   = '0;
                    chain_count_next = '0;
                    batch_sum_next   = item_reg.batch_end ? '0 : batch_new;
                    batch_count_next = item_reg.batch_end ? '0 : bcnt_new;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            chain_sum_reg   <= '0;
            batch_sum_reg   <= '0;
            chain_count_reg <= '0;
            batch_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            chain_sum_reg   <= chain_sum_next;
            batch_sum_reg   <= batch_sum_next;
            chain_count_reg <= chain_count_next;
            batch_count_reg <= batch_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        sq_x_reg      <= sq_x_next;
        sq_y_reg      <= sq_y_next;
        rad_reg       <= rad_next;
        rem_reg       <= rem_next;
        res_reg       <= res_next;
        cnt_reg       <= cnt_next;
        out_chain_reg <= out_chain_next;
        out_batch_reg <= out_batch_next;
        out_ccnt_reg  <= out_ccnt_next;
        out_bcnt_reg  <= out_bcnt_next;
        out_last_reg  <= out_last_next;
    end

    `PLA_ASSERT_IMPLY(a_rem_bound, clk, rst_n, state_reg == S_ROOT,
        rem_reg <= {res_reg, 1'b0}, "square root remainder exceeds twice the root")
    `PLA_ASSERT_ALWAYS(a_chain_sum_le_batch, clk, rst_n,
        pla_pkg::BATCH_BITS'(chain_sum_reg) <= batch_sum_reg, "chain sum above batch sum")
    `PLA_ASSERT_ALWAYS(a_chain_cnt_le_batch, clk, rst_n,
        chain_count_reg <= batch_count_reg, "chain count above batch count")
    `PLA_ASSERT_NEXT(a_start_skips_root, clk, rst_n,
        state_reg == S_IDLE && q_stat.not_empty && pop_item.chain_start,
        state_reg == S_ACCUM, "chain start point did not go straight to accumulate")

endmodule

// ===== rtl/polyline_length_accumulator.sv =====
// ----------------------------------------------------------------------------
// polyline_length_accumulator
// Sum Euclidean segment lengths of polyline chains and batches.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one point per transaction:
//   signed Q16.8 coord_x/coord_y plus chain_start, chain_end, batch_end.
//   Output channel (out_valid/out_ready) carries one result per chain end:
//   chain length, running batch length (both Q.8), chain and batch point
//   counts, and last_of_batch. All four sums saturate.
//   Flow: the front computes |dx|,|dy| as the point is taken and pushes it
//   into a two-entry queue. The back pops one point at a time; a point that
//   is not a chain start passes through pop, square, add, 25 root steps of
//   the bit-serial square root and accumulate, a chain start point only
//   through pop and accumulate. The square root unit sets the sustained
//   point rate. A result appears in the output register in the cycle after
//   its point's accumulate step.
//   Reset clears the stored previous point to (0,0), all sums and counts,
//   the queue and the output valid flag; the output data is not reset.
//   While the receiver stalls, the result holds in the output register; the
//   back stalls at the next chain end and the queue fills, then in_ready drops.
// ----------------------------------------------------------------------------
module polyline_length_accumulator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pla_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [pla_pkg::COORD_BITS-1:0] coord_y,
    input  logic                                  chain_start,
    input  logic                                  chain_end,
    input  logic                                  batch_end,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pla_pkg::CHAIN_BITS-1:0]        chain_length,
    output logic [pla_pkg::BATCH_BITS-1:0]        total_length,
    output logic [pla_pkg::COUNT_BITS-1:0]        chain_points,
    output logic [pla_pkg::COUNT_BITS-1:0]        total_points,
    output logic                                  last_of_batch
);

    // front to queue
    logic                push;
    pla_pkg::pla_item_t  push_item;
    // queue to back
    logic                pop;
    pla_pkg::pla_item_t  pop_item;
    pla_pkg::pla_qstat_t q_stat;

    // Measure each point against the previous one as it is accepted.
    pla_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .chain_start (chain_start),
        .chain_end   (chain_end),
        .batch_end   (batch_end),
        .q_stat      (q_stat),
        .push        (push),
        .push_item   (push_item)
    );

    // Decouple the front, which measures each point as it is accepted, from the bit-serial back.
    pla_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    // Square, root, accumulate, and hold the result for the receiver.
    pla_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop_item      (pop_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .chain_length  (chain_length),
        .total_length  (total_length),
        .chain_points  (chain_points),
        .total_points  (total_points),
        .last_of_batch (last_of_batch)
    );

endmodule

// ===== tb/polyline_length_accumulator_checker.sv =====
// ----------------------------------------------------------------------------
// polyline_length_accumulator_checker
// Watches both channels, predicts each chain result from the accepted points
// and compares it, field by field, with the result that the block returns.
// ----------------------------------------------------------------------------
module polyline_length_accumulator_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic signed [pla_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [pla_pkg::COORD_BITS-1:0] coord_y,
    input  logic                                  chain_start,
    input  logic                                  chain_end,
    input  logic                                  batch_end,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic [pla_pkg::CHAIN_BITS-1:0]        chain_length,
    input  logic [pla_pkg::BATCH_BITS-1:0]        total_length,
    input  logic [pla_pkg::COUNT_BITS-1:0]        chain_points,
    input  logic [pla_pkg::COUNT_BITS-1:0]        total_points,
    input  logic                                  last_of_batch,
    output int                                    mismatches,
    output int                                    outstanding,
    output int                                    results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = pla_pkg::COORD_BITS;
    localparam logic [63:0] CHAIN_SAT = (64'd1 << pla_pkg::CHAIN_BITS) - 64'd1;
    localparam logic [63:0] BATCH_SAT = (64'd1 << pla_pkg::BATCH_BITS) - 64'd1;
    localparam logic [63:0] COUNT_SAT = (64'd1 << pla_pkg::COUNT_BITS) - 64'd1;

    typedef struct packed {
        logic [pla_pkg::CHAIN_BITS-1:0] chain_length;
        logic [pla_pkg::BATCH_BITS-1:0] total_length;
        logic [pla_pkg::COUNT_BITS-1:0] chain_points;
        logic [pla_pkg::COUNT_BITS-1:0] total_points;
        logic                           last_of_batch;
    } chain_report_t;

    chain_report_t expected_reports[$];

    // Predicted block state
    logic signed [CW-1:0] last_x = '0;
    logic signed [CW-1:0] last_y = '0;
    logic [63:0]          chain_acc = '0;
    logic [63:0]          batch_acc = '0;
    logic [63:0]          chain_cnt = '0;
    logic [63:0]          batch_cnt = '0;
    int                   bad_reports = 0;
    int                   good_reports = 0;

    function automatic logic [63:0] clamp_add(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] ceiling);
        logic [63:0] s;
        s = a + b;
        return (s > ceiling) ? ceiling : s;
    endfunction

    function automatic logic [63:0] span(input logic signed [CW-1:0] a,
                                         input logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
        return (d < 0) ? 64'(-d) : 64'(d);
    endfunction

    // Floor square root, two radicand bits per step
    function automatic logic [63:0] floor_root(input logic [63:0] radicand);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
        rem  = '0;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            rem   = (rem << 2) | ((radicand >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    task automatic track_point();
        logic [63:0]   dx;
        logic [63:0]   dy;
        logic [63:0]   seg;
        chain_report_t rpt;
        if (chain_start) begin
            chain_acc = '0;
            chain_cnt = '0;
        end else begin
            dx        = span(coord_x, last_x);
            dy        = span(coord_y, last_y);
            seg       = floor_root(dx * dx + dy * dy);
            chain_acc = clamp_add(chain_acc, seg, CHAIN_SAT);
            batch_acc = clamp_add(batch_acc, seg, BATCH_SAT);
        end
        last_x    = coord_x;
        last_y    = coord_y;
        chain_cnt = clamp_add(chain_cnt, 64'd1, COUNT_SAT);
        batch_cnt = clamp_add(batch_cnt, 64'd1, COUNT_SAT);
        if (chain_end) begin
            rpt.chain_length  = chain_acc[pla_pkg::CHAIN_BITS-1:0];
            rpt.total_length  = batch_acc[pla_pkg::BATCH_BITS-1:0];
            rpt.chain_points  = chain_cnt[pla_pkg::COUNT_BITS-1:0];
            rpt.total_points  = batch_cnt[pla_pkg::COUNT_BITS-1:0];
            rpt.last_of_batch = batch_end;
            expected_reports.push_back(rpt);
            chain_acc = '0;
            chain_cnt = '0;
            if (batch_end) begin
                batch_acc = '0;
                batch_cnt = '0;
            end
        end
    endtask

    task automatic match_report();
        chain_report_t got;
        chain_report_t want;
        got = '{chain_length, total_length, chain_points, total_points, last_of_batch};
        good_reports++;
        if (expected_reports.size() == 0) begin
            bad_reports++;
            if (bad_reports <= 10)
                $display("[%0t] unexpected result: len=%0d total=%0d pts=%0d tpts=%0d last=%0b",
                         $realtime, got.chain_length, got.total_length, got.chain_points,
                         got.total_points, got.last_of_batch);
        end else begin
            want = expected_reports.pop_front();
            if (got !== want) begin
                bad_reports++;
                if (bad_reports <= 10) begin
                    $display("[%0t] result mismatch", $realtime);
                    $display("    chain_length  exp %0d got %0d",
                             want.chain_length, got.chain_length);
                    $display("    total_length  exp %0d got %0d",
                             want.total_length, got.total_length);
                    $display("    chain_points  exp %0d got %0d",
                             want.chain_points, got.chain_points);
                    $display("    total_points  exp %0d got %0d",
                             want.total_points, got.total_points);
                    $display("    last_of_batch exp %0b got %0b",
                             want.last_of_batch, got.last_of_batch);
                end
            end
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            last_x    = '0;
            last_y    = '0;
            chain_acc = '0;
            batch_acc = '0;
            chain_cnt = '0;
            batch_cnt = '0;
            expected_reports.delete();
        end else begin
            // Retire the output first: it never belongs to a point taken at this edge
            if (out_valid && out_ready)
                match_report();
            if (in_valid && in_ready)
                track_point();
        end
        mismatches   <= bad_reports;
        outstanding  <= expected_reports.size();
        results_seen <= good_reports;
    end

endmodule

// ===== tb/tb_polyline_length_accumulator.sv =====
// ----------------------------------------------------------------------------
// tb_polyline_length_accumulator
// Drives polyline points into the length accumulator: a directed set of edge
// cases, then random chains under three idling patterns; a checker module
// predicts and compares every chain result.
// ----------------------------------------------------------------------------
module tb_polyline_length_accumulator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = pla_pkg::COORD_BITS;
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW - 1){1'b0}}};
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 60;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic signed [CW-1:0]           coord_x = '0;
    logic signed [CW-1:0]           coord_y = '0;
    logic                           chain_start = 1'b0;
    logic                           chain_end = 1'b0;
    logic                           batch_end = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [pla_pkg::CHAIN_BITS-1:0] chain_length;
    logic [pla_pkg::BATCH_BITS-1:0] total_length;
    logic [pla_pkg::COUNT_BITS-1:0] chain_points;
    logic [pla_pkg::COUNT_BITS-1:0] total_points;
    logic                           last_of_batch;

    int mismatches;
    int outstanding;
    int results_seen;

    // Idle odds in percent, changed between phases
    int src_idle_pct  = 6;
    int sink_idle_pct = 72;

    // Last coordinates sent, the seed of the next random point
    logic signed [CW-1:0] walk_x = '0;
    logic signed [CW-1:0] walk_y = '0;
    int points_sent = 0;
    int chains_closed = 0;

    always #10 clk = ~clk;

    polyline_length_accumulator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .chain_start   (chain_start),
        .chain_end     (chain_end),
        .batch_end     (batch_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .chain_length  (chain_length),
        .total_length  (total_length),
        .chain_points  (chain_points),
        .total_points  (total_points),
        .last_of_batch (last_of_batch)
    );

    polyline_length_accumulator_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .chain_start   (chain_start),
        .chain_end     (chain_end),
        .batch_end     (batch_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .chain_length  (chain_length),
        .total_length  (total_length),
        .chain_points  (chain_points),
        .total_points  (total_points),
        .last_of_batch (last_of_batch),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .results_seen  (results_seen)
    );

    // Receiver: drop ready at random with the current odds; hold it low in reset
    always @(posedge clk) begin
        out_ready <= rst_n && ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Present one point and hold it until the transaction completes.
    // Called at a rising edge; returns at the edge that accepts the point.
    task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                              input logic s, input logic e, input logic b);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            // Insert an idle gap before the point
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        in_valid    <= 1'b1;
        coord_x     <= x;
        coord_y     <= y;
        chain_start <= s;
        chain_end   <= e;
        batch_end   <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        walk_x = x;
        walk_y = y;
        points_sent++;
        if (e)
            chains_closed++;
    endtask

    // Pick the next coordinate: half the time a short step from the last one, else
    // a full-range jump or one of the extremes
    function automatic logic signed [CW-1:0] next_coord(input logic signed [CW-1:0] p);
        logic signed [CW-1:0] delta;
        delta = CW'($urandom_range(0, 2047)) - CW'(1024);
        case ($urandom_range(0, 9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2, 3, 4: return CW'($urandom);
            default: return p + delta;
        endcase
    endfunction

    // Edge cases: extremes, a segment from the reset origin, a lone batch end,
    // one-point chains, chains that pick up from the previous chain's last point
    task automatic run_directed();
        // Measure from the reset origin, no chain start
        send_point(COORD_MAX, COORD_MAX, 1'b0, 1'b0, 1'b0);
        // Longest possible segment, corner to corner
        send_point(COORD_MIN, COORD_MIN, 1'b0, 1'b1, 1'b0);
        // Batch end on a point that does not end a chain: keep the totals
        send_point(24'sd0, 24'sd0, 1'b1, 1'b0, 1'b1);
        send_point(COORD_MAX, COORD_MIN, 1'b0, 1'b1, 1'b1);
        // One-point chain
        send_point(24'sd123, -24'sd456, 1'b1, 1'b1, 1'b0);
        // No chain start: continue from the previous chain's last point
        send_point(24'sd5, -24'sd5, 1'b0, 1'b1, 1'b0);
        // Zero-length segment
        send_point(24'sd5, -24'sd5, 1'b0, 1'b1, 1'b1);
        send_point(COORD_MIN, COORD_MAX, 1'b1, 1'b0, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0, 1'b0, 1'b0);
        send_point(24'sd0, 24'sd0, 1'b0, 1'b1, 1'b1);
        // Small values around zero
        send_point(-24'sd1, 24'sd1, 1'b1, 1'b0, 1'b0);
        send_point(24'sd1, -24'sd1, 1'b0, 1'b0, 1'b0);
        send_point(-24'sd1, -24'sd1, 1'b0, 1'b1, 1'b0);
        // One-point chain that also closes the batch
        send_point(COORD_MIN, COORD_MIN, 1'b1, 1'b1, 1'b1);
        // Pure horizontal and vertical steps
        send_point(24'sd0, 24'sd0, 1'b1, 1'b0, 1'b0);
        send_point(24'sd256, 24'sd0, 1'b0, 1'b0, 1'b0);
        send_point(24'sd256, -24'sd768, 1'b0, 1'b1, 1'b1);
    endtask

    // Mostly well-formed chains with random content; a few points get random flags
    task automatic run_chains(input int n_points);
        int       sent;
        int       len;
        logic     s;
        logic     e;
        logic     b;
        logic [2:0] junk;
        sent = 0;
        while (sent < n_points) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                s = (k == 0) && ($urandom_range(0, 9) != 0);
                e = (k == len - 1);
                b = e && ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 99) < 8) begin
                    junk = 3'($urandom);
                    {s, e, b} = junk;
                end
                send_point(next_coord(walk_x), next_coord(walk_y), s, e, b);
                sent++;
            end
        end
    endtask

    // Watchdog: a correct run ends far sooner
    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int waited;
        // Hold reset, then release it at an edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: sender rarely idles, receiver mostly stalls
        src_idle_pct  = 6;
        sink_idle_pct = 72;
        run_directed();
        run_chains(170);

        // Phase 2: swap the idle pattern
        src_idle_pct  = 72;
        sink_idle_pct = 6;
        run_chains(170);

        // Phase 3: full rate on both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_chains(170);
        in_valid <= 1'b0;

        // Drain: wait for every expected result, then let the block settle
        waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while (outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d points closing %0d chains; %0d results checked, %0d mismatches",
                 points_sent, chains_closed, results_seen, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pla_pkg.sv
rtl/pla_front.sv
rtl/pla_queue.sv
rtl/pla_back.sv
rtl/polyline_length_accumulator.sv
tb/polyline_length_accumulator_checker.sv
tb/tb_polyline_length_accumulator.sv
